>>> hdl/pcrc_pkg.sv
// Shared types, constants and the bytewise CRC-32 update for the PNG chunk CRC checker.
package pcrc_pkg;

    // Default number of length bits kept as the data byte count
    localparam int LENGTH_BITS_DEFAULT = 31;
    // Width of the chunk_length result field
    localparam int OUT_LEN_BITS = 31;

    // Reset value of the header_skip register (PNG signature length)
    localparam logic [7:0] HEADER_SKIP_RESET = 8'd8;

    // Reflected CRC-32 polynomial and preset
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // Byte index of the last byte in a four-byte field
    localparam logic [1:0] FIELD_LAST = 2'd3;

    // Register index for the config port
    localparam logic REG_HEADER_SKIP = 1'b0;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_MATCH    = 2'd0,
        STATUS_MISMATCH = 2'd1,
        STATUS_TRUNC    = 2'd2
    } status_t;

    // One result item
    typedef struct packed {
        status_t                   status;
        logic [OUT_LEN_BITS-1:0]   chunk_length;
        logic [31:0]               chunk_type;
        logic [31:0]               computed_crc;
        logic [31:0]               stored_crc;
    } result_t;

    // One CRC-32 step over a byte, LSB first
    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] v;
        v = c ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
        end
        return v;
    endfunction

endpackage

>>> hdl/pcrc_parser.sv
// Input register and chunk parser: tracks phase, length, type and CRC, emits one result per chunk.
module pcrc_parser import pcrc_pkg::*; #(
    parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [7:0] header_skip,
    // incoming item
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_start,
    input  logic       in_end,
    // result toward the output buffer
    output logic       res_valid,
    input  logic       res_ready,
    output result_t    res_data
);

    typedef enum logic [2:0] {
        PH_SKIP = 3'd0,
        PH_LEN  = 3'd1,
        PH_TYPE = 3'd2,
        PH_DATA = 3'd3,
        PH_CRC  = 3'd4
    } phase_t;

    // input register
    logic       in_valid_reg;
    logic [7:0] byte_reg;
    logic       start_reg;
    logic       end_reg;

    // parser state
    phase_t                 phase_reg, phase_next;
    logic [7:0]             skip_count_reg, skip_count_next;
    logic [1:0]             fbi_reg, fbi_next;
    logic [LENGTH_BITS-1:0] remaining_reg, remaining_next;
    logic [LENGTH_BITS-1:0] length_reg, length_next;
    logic [31:0]            type_reg, type_next;
    logic [31:0]            crc_reg, crc_next;
    logic [31:0]            stored_reg, stored_next;

    logic    fire;
    logic    done;
    result_t res_next;

    assign fire     = in_valid_reg && res_ready;
    assign in_ready = !in_valid_reg || res_ready;

    // next state and result for the registered item
    always_comb begin
        logic        consumed;
        logic        between;
        logic [31:0] comp;
        logic [1:0]  fbi_inc;

        phase_next      = phase_reg;
        skip_count_next = skip_count_reg;
        fbi_next        = fbi_reg;
        remaining_next  = remaining_reg;
        length_next     = length_reg;
        type_next       = type_reg;
        crc_next        = crc_reg;
        stored_next     = stored_reg;
        consumed        = 1'b0;
        between         = 1'b0;
        done            = 1'b0;
        res_next        = '0;
        comp            = '0;

        // stream start restarts the parser before the byte is taken
        if (start_reg) begin
            phase_next      = PH_SKIP;
            skip_count_next = '0;
            fbi_next        = '0;
            remaining_next  = '0;
            length_next     = '0;
            type_next       = '0;
            crc_next        = CRC_INIT;
            stored_next     = '0;
        end

        // signature skip
        if (phase_next == PH_SKIP) begin
            if (skip_count_next < header_skip) begin
                skip_count_next = skip_count_next + 8'd1;
                consumed        = 1'b1;
            end else begin
                phase_next = PH_LEN;
                fbi_next   = '0;
            end
        end

        fbi_inc = fbi_next + 2'd1;

        if (!consumed) begin
            unique case (phase_next)
                PH_TYPE: begin
                    type_next = {type_next[23:0], byte_reg};
                    crc_next  = crc_byte(crc_next, byte_reg);
                    if (fbi_next == FIELD_LAST) begin
                        phase_next = (remaining_next == '0) ? PH_CRC : PH_DATA;
                    end
                    fbi_next = fbi_inc;
                end
                PH_DATA: begin
                    crc_next       = crc_byte(crc_next, byte_reg);
                    remaining_next = remaining_next - LENGTH_BITS'(1);
                    if (remaining_next == '0) begin
                        phase_next = PH_CRC;
                        fbi_next   = '0;
                    end
                end
                PH_CRC: begin
                    stored_next = {stored_next[23:0], byte_reg};
                    if (fbi_next == FIELD_LAST) begin
                        comp                  = ~crc_next;
                        res_next.status       = (comp == stored_next) ? STATUS_MATCH
                                                                      : STATUS_MISMATCH;
                        res_next.chunk_length = OUT_LEN_BITS'(length_next);
                        res_next.chunk_type   = type_next;
                        res_next.computed_crc = comp;
                        res_next.stored_crc   = stored_next;
                        done                  = 1'b1;
                        phase_next            = PH_LEN;
                    end
                    fbi_next = fbi_inc;
                end
                default: begin
                    // length field; first byte clears the chunk context
                    if (fbi_next == '0) begin
                        length_next = '0;
                        type_next   = '0;
                        stored_next = '0;
                        crc_next    = CRC_INIT;
                    end
                    length_next = LENGTH_BITS'({length_next, byte_reg});
                    phase_next  = PH_LEN;
                    if (fbi_next == FIELD_LAST) begin
                        remaining_next = length_next;
                        phase_next     = PH_TYPE;
                    end
                    fbi_next = fbi_inc;
                end
            endcase
        end

        // stream end: report a cut chunk, then restart
        if (end_reg) begin
            between = (phase_next == PH_SKIP) || (phase_next == PH_LEN && fbi_next == '0);
            if (!done && !between) begin
                res_next        = '0;
                res_next.status = STATUS_TRUNC;
                done            = 1'b1;
            end
            phase_next      = PH_SKIP;
            skip_count_next = '0;
            fbi_next        = '0;
            remaining_next  = '0;
            length_next     = '0;
            type_next       = '0;
            crc_next        = CRC_INIT;
            stored_next     = '0;
        end
    end

    assign res_valid = fire && done;
    assign res_data  = res_next;

    // input register and parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            phase_reg      <= PH_SKIP;
            skip_count_reg <= '0;
            fbi_reg        <= '0;
            remaining_reg  <= '0;
            length_reg     <= '0;
            type_reg       <= '0;
            crc_reg        <= CRC_INIT;
            stored_reg     <= '0;
        end else begin
            if (in_ready) begin
                in_valid_reg <= in_valid;
            end
            if (fire) begin
                phase_reg      <= phase_next;
                skip_count_reg <= skip_count_next;
                fbi_reg        <= fbi_next;
                remaining_reg  <= remaining_next;
                length_reg     <= length_next;
                type_reg       <= type_next;
                crc_reg        <= crc_next;
                stored_reg     <= stored_next;
            end
        end
    end

    // payload of the input register
    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            byte_reg  <= in_byte;
            start_reg <= in_start;
            end_reg   <= in_end;
        end
    end

endmodule

>>> hdl/pcrc_skid.sv
// Result register with a skid stage so the parser keeps running while a result waits.
module pcrc_skid import pcrc_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  result_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data,
    output logic    skid_full
);

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    load_out;

    assign load_out  = !out_valid_reg || out_ready;
    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign skid_full = skid_valid_reg;

    // valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (load_out) begin
            out_valid_reg  <= skid_valid_reg || in_valid;
            skid_valid_reg <= 1'b0;
        end else if (in_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end else if (in_valid && !skid_valid_reg) begin
            skid_data_reg <= in_data;
        end
    end

endmodule

>>> hdl/png_chunk_crc_checker.sv
// PNG chunk CRC checker top level: stream ports, config register and assertions.
//
// Takes one PNG byte per cycle on the s_ stream while s_tready is high and, after
// skipping header_skip signature bytes, parses each chunk (length, type, data,
// stored CRC) and checks the CRC-32 over type and data bytes. One result item per
// chunk comes out on m_: match, mismatch, or truncated when the stream ends inside
// a chunk. Throughput is one byte every cycle while input is not stalled, set by
// the bytewise CRC update in the parser; a result reaches m_ through the input
// register, then the result register. A two-deep result buffer lets input continue
// while a result waits; input stalls only when both entries are full. header_skip
// is at APB address 0 and should be written only while the block is idle.
module png_chunk_crc_checker import pcrc_pkg::*; #(
    parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
    input  logic         aclk,
    input  logic         aresetn,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic [0:0]   s_tuser,   // [0] stream_start
    input  logic         s_tlast,   // stream_end
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // [30:0] chunk_length, [62:31] chunk_type, [94:63] computed_crc,
    // [126:95] stored_crc, [127] zero
    output logic [127:0] m_tdata,
    output logic [1:0]   m_tuser,   // [1:0] status
    // config port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [7:0] header_skip_reg;
    logic       res_valid;
    logic       res_ready;
    result_t    res_data;
    result_t    out_data;
    logic       skid_full;

    // config register
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_skip_reg <= HEADER_SKIP_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_HEADER_SKIP) begin
            header_skip_reg <= pwdata[7:0];
        end
    end

    assign prdata = (paddr[2] == REG_HEADER_SKIP) ? {24'd0, header_skip_reg} : 32'd0;

    pcrc_parser #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .header_skip (header_skip_reg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_byte     (s_tdata),
        .in_start    (s_tuser[0]),
        .in_end      (s_tlast),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_data    (res_data)
    );

    pcrc_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_ready  (res_ready),
        .in_data   (res_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data),
        .skid_full (skid_full)
    );

    // result packing
    assign m_tuser = out_data.status;
    assign m_tdata = {1'b0, out_data.stored_crc, out_data.computed_crc,
                      out_data.chunk_type, out_data.chunk_length};

    // a held skid entry means the output register is occupied too
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_full |-> m_tvalid)
        else $error("skid entry held while output register empty");

    // no undefined status code leaves the block
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == STATUS_MATCH || m_tuser == STATUS_MISMATCH ||
                      m_tuser == STATUS_TRUNC))
        else $error("undefined status on result");

    // a truncated chunk carries an all-zero payload
    a_trunc_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == STATUS_TRUNC) |-> (m_tdata == '0))
        else $error("truncated result with nonzero payload");

    // mismatch status agrees with the reported CRC values
    a_status_crc: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != STATUS_TRUNC) |->
            ((m_tuser == STATUS_MATCH) == (m_tdata[94:63] == m_tdata[126:95])))
        else $error("status disagrees with CRC fields");

endmodule

>>> bench/testbench.sv
// Self-checking testbench for png_chunk_crc_checker: directed and random PNG byte streams.
//
// Bytes go in on the s_ stream with random gaps; a parser model kept here follows
// every byte and queues the chunk result that byte should produce. Results on m_
// are checked field by field against that queue. A short directed table (PNG
// signature, an IEND chunk, a cut-off oversized chunk) runs first on reset
// settings. Random phases then follow, each with its own header_skip, including
// 0 and 255 and a write made while a stream sits in its signature. The streams
// carry good and bad CRCs, empty chunks, oversized lengths, truncation, missing
// stream_start and pure noise. One phase holds m_tready low for a long stretch.
// Another runs with no idling on either side.
module testbench import pcrc_pkg::*; ();

    localparam int          ITEM_TARGET = 1550;
    localparam int          N_PHASES    = 7;
    localparam int          IDLE_PCT    = 13;
    localparam int          SINK_STALL  = 400;
    localparam logic [2:0]  SKIP_ADDR   = 3'(4 * REG_HEADER_SKIP);

    // Parser position, kept here for prediction
    typedef enum logic [2:0] {
        AT_SIGNATURE, AT_LENGTH, AT_TYPE, AT_BODY, AT_CRC
    } parse_pos_t;

    // How a directed row gets its expected result
    typedef enum logic [1:0] {
        WANT_PREDICTED, WANT_IEND, WANT_CUT
    } want_t;

    typedef struct packed {
        logic [7:0] b;
        logic       sos;
        logic       eos;
        want_t      want;
    } dir_row_t;

    // IEND has a fixed, well-known CRC
    localparam result_t IEND_OK = '{STATUS_MATCH, 31'd0, 32'h4945_4E44,
                                    32'hAE42_6082, 32'hAE42_6082};
    localparam result_t CUT_SHORT = '{STATUS_TRUNC, 31'd0, 32'd0, 32'd0, 32'd0};

    // Signature, IEND chunk, then an all-ones length cut off in its type field
    localparam dir_row_t DIR_ROWS [25] = '{
        '{8'h89, 1'b1, 1'b0, WANT_PREDICTED}, '{8'h50, 1'b0, 1'b0, WANT_PREDICTED},
        '{8'h4E, 1'b0, 1'b0, WANT_PREDICTED}, '{8'h47, 1'b0, 1'b0, WANT_PREDICTED},
        '{8'h0D, 1'b0, 1'b0, WANT_PREDICTED}, '{8'h0A, 1'b0, 1'b0, WANT_PREDICTED},
        '{8'h1A, 1'b0, 1'b0, WANT_PREDICTED}, '{8'h0A, 1'b0, 1'b0, WANT_PREDICTED},
        '{8'h00, 1'b0, 1'b0, WANT_PREDICTED}, '{8'h00, 1'b0, 1'b0, WANT_PREDICTED},
        '{8'h00, 1'b0, 1'b0, WANT_PREDICTED}, '{8'h00, 1'b0, 1'b0, WANT_PREDICTED},
        '{8'h49, 1'b0, 1'b0, WANT_PREDICTED}, '{8'h45, 1'b0, 1'b0, WANT_PREDICTED},
        '{8'h4E, 1'b0, 1'b0, WANT_PREDICTED}, '{8'h44, 1'b0, 1'b0, WANT_PREDICTED},
        '{8'hAE, 1'b0, 1'b0, WANT_PREDICTED}, '{8'h42, 1'b0, 1'b0, WANT_PREDICTED},
        '{8'h60, 1'b0, 1'b0, WANT_PREDICTED}, '{8'h82, 1'b0, 1'b0, WANT_IEND},
        '{8'hFF, 1'b0, 1'b0, WANT_PREDICTED}, '{8'hFF, 1'b0, 1'b0, WANT_PREDICTED},
        '{8'hFF, 1'b0, 1'b0, WANT_PREDICTED}, '{8'hFF, 1'b0, 1'b0, WANT_PREDICTED},
        '{8'h00, 1'b0, 1'b1, WANT_CUT}
    };

    logic         aclk = 1'b0;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;
    logic [0:0]   s_tuser;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    // Model state
    logic [7:0]   skip_cfg;
    parse_pos_t   pos;
    logic [7:0]   sig_seen;
    logic [1:0]   fld_idx;
    logic [30:0]  body_left;
    logic [30:0]  len_q;
    logic [31:0]  type_q;
    logic [31:0]  crc_run;
    logic [31:0]  crc_got;

    result_t      pending_chunks[$];
    int           fail_cnt;
    int           items_sent;
    int           sink_hold;
    bit           steady;

    png_chunk_crc_checker u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Bitwise CRC-32 step, input bits taken LSB first
    function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] x;
        x = c;
        for (int i = 0; i < 8; i++) begin
            if (x[0] ^ b[i])
                x = (x >> 1) ^ CRC_POLY;
            else
                x = x >> 1;
        end
        return x;
    endfunction

    function automatic void rewind_parser();
        pos       = AT_SIGNATURE;
        sig_seen  = '0;
        fld_idx   = '0;
        body_left = '0;
        len_q     = '0;
        type_q    = '0;
        crc_run   = CRC_INIT;
        crc_got   = '0;
    endfunction

    // Follow one byte through the parser; returns 1 when it finishes a chunk
    function automatic bit track_byte(input logic [7:0] b, input bit sos, input bit eos,
                                      output result_t r);
        bit got;
        bit take;
        got      = 1'b0;
        take     = 1'b1;
        r        = '0;
        if (sos)
            rewind_parser();
        if (pos == AT_SIGNATURE) begin
            if (sig_seen < skip_cfg) begin
                sig_seen = sig_seen + 8'd1;
                take     = 1'b0;
            end else begin
                pos     = AT_LENGTH;
                fld_idx = '0;
            end
        end
        if (take) begin
            case (pos)
                AT_TYPE: begin
                    type_q  = {type_q[23:0], b};
                    crc_run = crc_step(crc_run, b);
                    fld_idx = fld_idx + 2'd1;
                    if (fld_idx == 2'd0)
                        pos = (body_left == '0) ? AT_CRC : AT_BODY;
                end
                AT_BODY: begin
                    crc_run   = crc_step(crc_run, b);
                    body_left = body_left - 31'd1;
                    if (body_left == '0) begin
                        pos     = AT_CRC;
                        fld_idx = '0;
                    end
                end
                AT_CRC: begin
                    crc_got = {crc_got[23:0], b};
                    fld_idx = fld_idx + 2'd1;
                    if (fld_idx == 2'd0) begin
                        r.status       = (~crc_run == crc_got) ? STATUS_MATCH : STATUS_MISMATCH;
                        r.chunk_length = len_q;
                        r.chunk_type   = type_q;
                        r.computed_crc = ~crc_run;
                        r.stored_crc   = crc_got;
                        got            = 1'b1;
                        pos            = AT_LENGTH;
                    end
                end
                default: begin
                    // length field; its first byte opens a new chunk
                    if (fld_idx == 2'd0) begin
                        len_q   = '0;
                        type_q  = '0;
                        crc_got = '0;
                        crc_run = CRC_INIT;
                    end
                    len_q   = {len_q[22:0], b};
                    fld_idx = fld_idx + 2'd1;
                    pos     = AT_LENGTH;
                    if (fld_idx == 2'd0) begin
                        body_left = len_q;
                        pos       = AT_TYPE;
                    end
                end
            endcase
        end
        if (eos) begin
            // ending in the signature or cleanly between chunks is silent
            if (!got && !(pos == AT_SIGNATURE || (pos == AT_LENGTH && fld_idx == 2'd0))) begin
                r        = CUT_SHORT;
                got      = 1'b1;
            end
            rewind_parser();
        end
        return got;
    endfunction

    task automatic flag(input string msg);
        fail_cnt++;
        if (fail_cnt <= 10)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // Offer one item and wait for it to be taken
    task automatic drive(input logic [7:0] b, input bit sos, input bit eos);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= sos;
        s_tlast  <= eos;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    task automatic emit(input logic [7:0] b, input bit sos, input bit eos);
        result_t r;
        if (track_byte(b, sos, eos, r))
            pending_chunks.push_back(r);
        items_sent++;
        drive(b, sos, eos);
    endtask

    // Stop sending, let every queued chunk come out, then allow the pipe to empty
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_chunks.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Write header_skip, then read it back
    task automatic write_skip(input logic [7:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SKIP_ADDR;
        pwdata  <= 32'(v);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        skip_cfg = v;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        if (prdata !== 32'(v))
            flag($sformatf("header_skip readback %h, wrote %h", prdata, v));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // One random stream; without fresh it continues the open stream with no signature
    task automatic run_stream(input bit fresh);
        logic [7:0]  bytes[$];
        logic [7:0]  b;
        logic [31:0] len_field;
        logic [31:0] crc;
        int unsigned n_sig;
        int unsigned body;
        int unsigned r;
        int unsigned cut;
        int          k;
        bit          with_sos;
        bit          with_eos;
        if (fresh && $urandom_range(0, 99) < 12) begin
            // noise: random bytes and flags
            repeat ($urandom_range(1, 24))
                emit(8'($urandom), $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0);
            return;
        end
        n_sig = 0;
        if (fresh) begin
            n_sig = 32'(skip_cfg);
            if ($urandom_range(0, 19) == 0)
                n_sig = $urandom_range(0, 32'(skip_cfg));
        end
        repeat (n_sig) bytes.push_back(8'($urandom));
        repeat ($urandom_range(1, 4)) begin
            body = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
            len_field = 32'(body);
            // oversized length: only the low bits count
            if ($urandom_range(0, 11) == 0)
                len_field[31] = 1'b1;
            for (k = 3; k >= 0; k--)
                bytes.push_back(len_field[8*k +: 8]);
            crc = CRC_INIT;
            repeat (4 + body) begin
                b = 8'($urandom);
                bytes.push_back(b);
                crc = crc_step(crc, b);
            end
            crc = ~crc;
            if ($urandom_range(0, 3) == 0)
                crc ^= 32'h1 << $urandom_range(0, 31);
            for (k = 3; k >= 0; k--)
                bytes.push_back(crc[8*k +: 8]);
        end
        r = $urandom_range(0, 99);
        // truncated: stream ends at a random byte inside the chunks
        if (r < 20 && bytes.size() > n_sig + 1) begin
            cut = $urandom_range(n_sig, bytes.size() - 2);
            while (bytes.size() > cut + 1)
                void'(bytes.pop_back());
        end
        with_eos = (r < 90);
        with_sos = fresh && ($urandom_range(0, 9) != 0);
        foreach (bytes[i])
            emit(bytes[i], with_sos && i == 0, with_eos && i == bytes.size() - 1);
    endtask

    // Result sink handshake: random idling, or a counted hold when requested
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (sink_hold != 0) begin
                m_tready <= 1'b0;
                sink_hold--;
            end else begin
                m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // Result checker
    always @(posedge aclk) begin : result_check
        result_t seen;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            seen.status       = status_t'(m_tuser);
            seen.chunk_length = m_tdata[30:0];
            seen.chunk_type   = m_tdata[62:31];
            seen.computed_crc = m_tdata[94:63];
            seen.stored_crc   = m_tdata[126:95];
            if (pending_chunks.size() == 0) begin
                flag($sformatf("unexpected item status=%0d len=%h type=%h crc=%h/%h",
                     seen.status, seen.chunk_length, seen.chunk_type,
                     seen.computed_crc, seen.stored_crc));
            end else begin
                want = pending_chunks.pop_front();
                if (seen !== want)
                    flag($sformatf({"chunk result: status %0d/%0d len %h/%h type %h/%h ",
                         "computed %h/%h stored %h/%h (expected/actual)"},
                         want.status, seen.status, want.chunk_length, seen.chunk_length,
                         want.chunk_type, seen.chunk_type, want.computed_crc,
                         seen.computed_crc, want.stored_crc, seen.stored_crc));
            end
        end
    end

    // Watchdog
    initial begin
        #5000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        result_t     r;
        bit          got;
        logic [7:0]  next_skip;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        s_tlast  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        fail_cnt   = 0;
        items_sent = 0;
        sink_hold  = 0;
        steady     = 1'b0;
        skip_cfg   = HEADER_SKIP_RESET;
        rewind_parser();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed rows on reset settings
        foreach (DIR_ROWS[i]) begin
            got = track_byte(DIR_ROWS[i].b, DIR_ROWS[i].sos, DIR_ROWS[i].eos, r);
            case (DIR_ROWS[i].want)
                WANT_IEND: begin
                    got = 1'b1;
                    r   = IEND_OK;
                end
                WANT_CUT: begin
                    got = 1'b1;
                    r   = CUT_SHORT;
                end
                default: ;
            endcase
            if (got)
                pending_chunks.push_back(r);
            drive(DIR_ROWS[i].b, DIR_ROWS[i].sos, DIR_ROWS[i].eos);
        end
        settle();

        // Open a stream, stop inside its signature, shrink header_skip, continue
        emit(8'($urandom), 1'b1, 1'b0);
        emit(8'($urandom), 1'b0, 1'b0);
        emit(8'($urandom), 1'b0, 1'b0);
        settle();
        write_skip(8'd1);
        run_stream(1'b0);

        // Random phases, each with its own header_skip
        for (int p = 0; p < N_PHASES; p++) begin
            if (p != 0) begin
                settle();
                case (p)
                    1: next_skip = 8'd0;
                    2: next_skip = 8'd255;
                    3: next_skip = HEADER_SKIP_RESET;
                    5: next_skip = 8'd2;
                    6: next_skip = 8'($urandom_range(0, 20));
                    default: next_skip = 8'($urandom_range(0, 255));
                endcase
                write_skip(next_skip);
            end
            steady = (p == 3);
            if (p == 1)
                sink_hold = SINK_STALL;
            while (items_sent < ITEM_TARGET * (p + 1) / N_PHASES)
                run_stream(1'b1);
        end
        steady = 1'b0;

        settle();
        repeat (6) @(posedge aclk);
        if (fail_cnt == 0 && pending_chunks.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
